@@ rtl/core/hfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfrc_pkg
// shared types and helpers for the binary16 reduce combiner
// ----------------------------------------------------------------------------
package hfrc_pkg;

    typedef enum logic [1:0] {
        CMD_SUM = 2'd0,
        CMD_MIN = 2'd1,
        CMD_MAX = 2'd2,
        CMD_MUL = 2'd3
    } t_cmd;

    localparam logic [15:0] QUIET_BIT   = 16'h0200;
    localparam logic [15:0] DEFAULT_NAN = 16'hFE00;
    localparam logic [15:0] INF_BITS    = 16'h7C00;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] acc;
        logic [15:0] inc;
        logic        last;
    } t_item;

    function automatic logic is_nan16(input logic [15:0] b);
        return (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
    endfunction

    function automatic logic is_inf16(input logic [15:0] b);
        return b[14:0] == 15'h7C00;
    endfunction

    function automatic logic is_zero16(input logic [15:0] b);
        return b[14:0] == 15'd0;
    endfunction

    function automatic logic [16:0] order_key(input logic [15:0] b);
        if (b[15]) begin
            return 17'h08000 - {2'b00, b[14:0]};
        end
        return 17'h08000 + {1'b0, b};
    endfunction

endpackage

@@ rtl/core/hfrc_round.sv @@
// ----------------------------------------------------------------------------
// hfrc_round
// rounds sign * mag * 2^scale to binary16, nearest even
// ----------------------------------------------------------------------------
module hfrc_round (
    input  logic               i_sign,
    input  logic [41:0]        i_mag,
    input  logic signed [7:0]  i_scale,
    output logic [15:0]        o_bits
);
    logic [5:0]         w_p;
    logic signed [8:0]  w_e;
    logic signed [8:0]  w_qexp;
    logic signed [8:0]  w_sh;
    logic [41:0]        w_q;
    logic [41:0]        w_rem;
    logic [41:0]        w_half;
    logic [41:0]        w_mask;
    logic [11:0]        w_qr;
    logic signed [8:0]  w_qe;
    logic signed [8:0]  w_ef;

    always_comb begin
        w_p = 6'd0;
        for (int i = 0; i < 42; i++) begin
            if (i_mag[i]) begin
                w_p = 6'(i);
            end
        end
        w_e = $signed({3'b000, w_p}) + 9'(i_scale);
        if (w_e < -9'sd14) begin
            w_e = -9'sd14;
        end
        w_qexp = w_e - 9'sd10;
        w_sh   = w_qexp - 9'(i_scale);
        w_mask = '0;
        w_half = '0;
        w_rem  = '0;
        if (w_sh <= 0) begin
            w_q = i_mag << 6'(-w_sh);
        end else if (w_sh >= 9'sd42) begin
            w_q = '0;
        end else begin
            w_mask = (42'd1 << 6'(w_sh)) - 42'd1;
            w_half = 42'd1 << 6'(w_sh - 9'sd1);
            w_rem  = i_mag & w_mask;
            w_q    = i_mag >> 6'(w_sh);
            if (w_rem > w_half || (w_rem == w_half && w_q[0])) begin
                w_q = w_q + 42'd1;
            end
        end
        w_qr = w_q[11:0];
        w_qe = w_qexp;
        if (w_qr == 12'h800) begin
            w_qr = 12'h400;
            w_qe = w_qexp + 9'sd1;
        end
        w_ef = w_qe + 9'sd25;
        if (w_qr < 12'h400) begin
            o_bits = {i_sign, 5'd0, w_qr[9:0]};
        end else if (w_ef >= 9'sd31) begin
            o_bits = {i_sign, 15'h7C00};
        end else begin
            o_bits = {i_sign, w_ef[4:0], w_qr[9:0]};
        end
    end
endmodule

@@ rtl/core/hfrc_datapath.sv @@
// ----------------------------------------------------------------------------
// hfrc_datapath
// sum, product, min and max of two binary16 operands
// ----------------------------------------------------------------------------
module hfrc_datapath (
    input  hfrc_pkg::t_item i_item,
    output logic [15:0]     o_result
);
    import hfrc_pkg::*;

    logic [15:0]        a, b;
    logic [10:0]        ma, mb;
    logic [4:0]         ea, eb;
    logic [41:0]        sa, sb;
    logic [42:0]        ssum;
    logic               s_neg;
    logic [41:0]        add_mag;
    logic signed [7:0]  add_scale;
    logic [15:0]        add_r, mul_r;
    logic [21:0]        mul_prod;
    logic [41:0]        mul_mag;
    logic signed [7:0]  mul_scale;
    logic [15:0]        add_out, mul_out, nan_r, keep_acc;
    logic               any_nan;

    assign a = i_item.acc;
    assign b = i_item.inc;

    always_comb begin
        ma = (a[14:10] == 5'd0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
        mb = (b[14:10] == 5'd0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
        ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        if (ea >= eb) begin
            sa = 42'(ma) << (ea - eb);
            sb = 42'(mb);
            add_scale = 8'(eb) - 8'sd25;
        end else begin
            sa = 42'(ma);
            sb = 42'(mb) << (eb - ea);
            add_scale = 8'(ea) - 8'sd25;
        end
        if (a[15] == b[15]) begin
            ssum  = {1'b0, sa} + {1'b0, sb};
            s_neg = a[15];
        end else if (sa >= sb) begin
            ssum  = {1'b0, sa - sb};
            s_neg = a[15];
        end else begin
            ssum  = {1'b0, sb - sa};
            s_neg = b[15];
        end
        add_mag   = ssum[41:0];
        mul_prod  = ma * mb;
        mul_mag   = 42'(mul_prod);
        mul_scale = 8'(ea) + 8'(eb) - 8'sd50;
    end

    hfrc_round u_add_round (
        .i_sign  (s_neg),
        .i_mag   (add_mag),
        .i_scale (add_scale),
        .o_bits  (add_r)
    );

    hfrc_round u_mul_round (
        .i_sign  (a[15] ^ b[15]),
        .i_mag   (mul_mag),
        .i_scale (mul_scale),
        .o_bits  (mul_r)
    );

    always_comb begin
        any_nan  = is_nan16(a) || is_nan16(b);
        nan_r    = is_nan16(b) ? (b | QUIET_BIT) : (a | QUIET_BIT);
        keep_acc = is_nan16(a) ? (a | QUIET_BIT) : a;
        priority if (any_nan) begin
            add_out = nan_r;
        end else if (is_inf16(a) && is_inf16(b)) begin
            add_out = (a[15] ^ b[15]) ? DEFAULT_NAN : a;
        end else if (is_inf16(a)) begin
            add_out = a;
        end else if (is_inf16(b)) begin
            add_out = b;
        end else if (ssum == 43'd0) begin
            add_out = {a[15] & b[15], 15'd0};
        end else begin
            add_out = add_r;
        end
        priority if (any_nan) begin
            mul_out = nan_r;
        end else if (is_inf16(a) || is_inf16(b)) begin
            mul_out = (is_zero16(a) || is_zero16(b)) ? DEFAULT_NAN
                                                     : {a[15] ^ b[15], 15'h7C00};
        end else if (is_zero16(a) || is_zero16(b)) begin
            mul_out = {a[15] ^ b[15], 15'd0};
        end else begin
            mul_out = mul_r;
        end
        unique case (i_item.cmd)
            CMD_SUM: o_result = add_out;
            CMD_MUL: o_result = mul_out;
            CMD_MIN: o_result = any_nan ? keep_acc
                              : ((order_key(b) < order_key(a)) ? b : a);
            CMD_MAX: o_result = any_nan ? keep_acc
                              : ((order_key(a) < order_key(b)) ? b : a);
            default: o_result = INF_BITS;
        endcase
    end
endmodule

@@ rtl/core/half_float_reduce_combiner_top.sv @@
// ----------------------------------------------------------------------------
// half_float_reduce_combiner_top
// elementwise binary16 sum, min, max and product with a last flag
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled: an item is registered
// at the input, combined in one pass of logic (align, add or multiply, round)
// and lands in the result register, which raises o_valid. The result
// register holds while o_valid is stalled, and the input stage refills as
// soon as the result register is free or being emptied in the same cycle.
module half_float_reduce_combiner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_acc_bits,
    input  logic [15:0] i_incoming_bits,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_bits,
    output logic        o_last_out
);
    import hfrc_pkg::*;

    logic        r_in_vld, r_out_vld;
    t_item       r_item;
    logic [15:0] r_res;
    logic        r_last;
    logic [15:0] w_res;
    logic        w_out_move, w_in_move;

    assign w_out_move = !r_out_vld || !i_stall;
    assign w_in_move  = !r_in_vld || w_out_move;
    assign o_stall    = !w_in_move;

    hfrc_datapath u_dp (
        .i_item   (r_item),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_move) begin
                r_in_vld <= i_valid;
            end
            if (w_out_move) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_move && i_valid) begin
            r_item <= '{cmd: t_cmd'(i_command), acc: i_acc_bits,
                        inc: i_incoming_bits, last: i_last_in};
        end
        if (w_out_move && r_in_vld) begin
            r_res  <= w_res;
            r_last <= r_item.last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_bits = r_res;
    assign o_last_out    = r_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld && $stable(r_res))
        else $error("result changed under stall");
    a_nostall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> !o_stall)
        else $error("input stalled with empty output");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !o_stall |=> r_out_vld)
        else $error("item lost between stages");
endmodule

@@ verif/half_float_reduce_combiner_top_test.sv @@
// ----------------------------------------------------------------------------
// half_float_reduce_combiner_top_test
// drives binary16 operand pairs with random idling on both sides and checks
// every result against a behavioral predictor of sum, min, max and product
// ----------------------------------------------------------------------------
module half_float_reduce_combiner_top_test;
    import hfrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1800;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] acc;
        logic [15:0] inc;
        logic        last;
    } t_operands;

    typedef struct {
        logic [15:0] bits;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [15:0] i_acc_bits;
    logic [15:0] i_incoming_bits;
    logic        i_last_in;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_result_bits;
    logic        o_last_out;

    half_float_reduce_combiner_top dut (.*);

    t_operands pending_items[$];
    t_result   expected_results[$];
    int        mismatches;
    int        idle_cycles;
    bit        stimulus_done;
    int        send_wait;
    int        recv_wait;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit f16_nan(logic [15:0] b);
        return b[14:10] == 5'h1F && b[9:0] != 0;
    endfunction

    function automatic bit f16_inf(logic [15:0] b);
        return b[14:0] == 15'h7C00;
    endfunction

    function automatic int unsigned f16_rank(logic [15:0] b);
        return b[15] ? 32'h8000 - b[14:0] : 32'h8000 + b;
    endfunction

    // value = mag * 2^scale, rounded to nearest even
    function automatic logic [15:0] f16_round(logic sign, longint unsigned mag, int scale);
        int msb, e, qexp, sh;
        longint unsigned q, rem, half;
        msb = 63;
        while (mag[msb] == 1'b0) msb--;
        e = msb + scale;
        if (e < -14) e = -14;
        qexp = e - 10;
        sh = qexp - scale;
        if (sh <= 0) begin
            q = mag << (-sh);
        end else if (sh >= 63) begin
            q = 0;
        end else begin
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            q = mag >> sh;
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (q == 64'h800) begin
            q = 64'h400;
            qexp++;
        end
        if (q < 64'h400) return {sign, q[14:0]};
        if (qexp + 25 >= 31) return {sign, 15'h7C00};
        return {sign, 5'(qexp + 25), q[9:0]};
    endfunction

    function automatic longint unsigned f16_mant(logic [15:0] b);
        return b[14:10] == 0 ? {54'd0, b[9:0]} : {53'd0, 1'b1, b[9:0]};
    endfunction

    function automatic int f16_exp(logic [15:0] b);
        return b[14:10] == 0 ? 1 : int'(b[14:10]);
    endfunction

    function automatic logic [15:0] combine(t_cmd cmd, logic [15:0] a, logic [15:0] b);
        longint ma, mb, s;
        int ea, eb;
        logic sign;
        if (cmd == CMD_MIN || cmd == CMD_MAX) begin
            if (f16_nan(a) || f16_nan(b)) return f16_nan(a) ? (a | QUIET_BIT) : a;
            if (cmd == CMD_MIN) return f16_rank(b) < f16_rank(a) ? b : a;
            return f16_rank(a) < f16_rank(b) ? b : a;
        end
        if (f16_nan(b)) return b | QUIET_BIT;
        if (f16_nan(a)) return a | QUIET_BIT;
        ma = f16_mant(a);
        mb = f16_mant(b);
        ea = f16_exp(a);
        eb = f16_exp(b);
        if (cmd == CMD_SUM) begin
            if (f16_inf(a) && f16_inf(b)) return (a[15] ^ b[15]) ? DEFAULT_NAN : a;
            if (f16_inf(a)) return a;
            if (f16_inf(b)) return b;
            if (ea >= eb) ma = ma << (ea - eb);
            else mb = mb << (eb - ea);
            if (a[15]) ma = -ma;
            if (b[15]) mb = -mb;
            s = ma + mb;
            if (s == 0) return {a[15] & b[15], 15'd0};
            if (s < 0) return f16_round(1'b1, -s, (ea < eb ? ea : eb) - 25);
            return f16_round(1'b0, s, (ea < eb ? ea : eb) - 25);
        end
        sign = a[15] ^ b[15];
        if (f16_inf(a) || f16_inf(b)) begin
            if (a[14:0] == 0 || b[14:0] == 0) return DEFAULT_NAN;
            return {sign, 15'h7C00};
        end
        if (a[14:0] == 0 || b[14:0] == 0) return {sign, 15'd0};
        return f16_round(sign, ma * mb, ea + eb - 50);
    endfunction

    // mostly normal values, with a share of edge classes
    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 9))
            0: return {1'($urandom), 5'd0, 10'($urandom)};
            1: return {1'($urandom), 5'h1F, ($urandom_range(0, 1) ? 10'($urandom) : 10'd0)};
            2: return {1'($urandom), 15'd0};
            3: return {1'($urandom), 5'h1E, 10'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(t_cmd cmd, logic [15:0] a, logic [15:0] b, logic last);
        t_operands op;
        op.cmd = cmd;
        op.acc = a;
        op.inc = b;
        op.last = last;
        pending_items.push_back(op);
    endtask

    initial begin
        t_operands op;
        t_cmd      c;
        logic [15:0] near;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_command = CMD_SUM;
        i_acc_bits = '0;
        i_incoming_bits = '0;
        i_last_in = 1'b0;
        stimulus_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_item(CMD_SUM, 16'h7C00, 16'hFC00, 1'b0);
        queue_item(CMD_MUL, 16'h7C00, 16'h8000, 1'b1);
        queue_item(CMD_SUM, 16'h8000, 16'h8000, 1'b0);
        queue_item(CMD_SUM, 16'h3C00, 16'hBC00, 1'b1);
        queue_item(CMD_SUM, 16'h7BFF, 16'h7BFF, 1'b0);
        queue_item(CMD_MUL, 16'h0001, 16'h8001, 1'b1);
        queue_item(CMD_SUM, 16'h7C01, 16'hFE00, 1'b0);
        queue_item(CMD_MUL, 16'h3C00, 16'h7D55, 1'b1);
        queue_item(CMD_MIN, 16'h7C01, 16'h3C00, 1'b0);
        queue_item(CMD_MAX, 16'h3C00, 16'hFFFF, 1'b1);
        queue_item(CMD_MIN, 16'h8000, 16'h0000, 1'b0);
        queue_item(CMD_MAX, 16'h0000, 16'h8000, 1'b1);
        queue_item(CMD_MIN, 16'hFBFF, 16'h7BFF, 1'b0);
        queue_item(CMD_MAX, 16'hFBFF, 16'h7BFF, 1'b1);
        queue_item(CMD_SUM, 16'h0000, 16'hFFFF, 1'b0);
        queue_item(CMD_MUL, 16'hFFFF, 16'h0000, 1'b1);
        queue_item(CMD_SUM, 16'h3C00, 16'h1000, 1'b0);
        queue_item(CMD_MUL, 16'h5BFF, 16'h5BFF, 1'b1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c = t_cmd'($urandom_range(0, 3));
            op.acc = pick_half();
            // close operands exercise cancellation and equal compares
            near = op.acc + 16'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) near[15] = ~near[15];
            op.inc = $urandom_range(0, 3) == 0 ? near : pick_half();
            queue_item(c, op.acc, op.inc, 1'($urandom));
        end
        wait (pending_items.size() == 0);
        stimulus_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_operands op;
                    t_result r;
                    op = pending_items.pop_front();
                    r.bits = combine(op.cmd, op.acc, op.inc);
                    r.last = op.last;
                    expected_results.push_back(r);
                    i_valid <= 1'b1;
                    i_command <= op.cmd;
                    i_acc_bits <= op.acc;
                    i_incoming_bits <= op.inc;
                    i_last_in <= op.last;
                    send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end else begin
            send_wait <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_result r;
                int      draw;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: bits %h last %b", o_result_bits, o_last_out);
                end else begin
                    r = expected_results.pop_front();
                    if (o_result_bits !== r.bits || o_last_out !== r.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b, got %h/%b",
                                     r.bits, r.last, o_result_bits, o_last_out);
                    end
                end
                draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
                recv_wait <= (draw > 0) ? draw - 1 : 0;
                i_stall <= (draw > 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end else begin
            recv_wait <= 0;
            idle_cycles <= 0;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        send_wait = 0;
        recv_wait = 0;
        wait (i_rst_n);
        fork
            begin
                wait (stimulus_done && expected_results.size() == 0);
                repeat (20) @(posedge i_clk);
            end
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (mismatches == 0 && expected_results.size() == 0 && idle_cycles < WATCHDOG_LIMIT) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ half_float_reduce_combiner_top.f @@
rtl/core/hfrc_pkg.sv
rtl/core/hfrc_round.sv
rtl/core/hfrc_datapath.sv
rtl/core/half_float_reduce_combiner_top.sv
verif/half_float_reduce_combiner_top_test.sv
